@@ hdl/primitive_assembler_macros.svh @@
// assertion macros used by the pa_assembler module
// each check is compiled out when SYNTHESIS is defined
`ifndef PRIMITIVE_ASSEMBLER_MACROS_SVH
`define PRIMITIVE_ASSEMBLER_MACROS_SVH

`ifndef SYNTHESIS

// check sampled on clk_i, ignored while rst_ni is low
`define PA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check sampled on clk_i at every edge, reset included
`define PA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PA_ASSERT(label, prop, msg)
`define PA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ hdl/pa_pkg.sv @@
package pa_pkg;

  // fixed field widths of the ports
  localparam int unsigned FieldBits  = 16;
  localparam int unsigned ModeBits   = 4;
  localparam int unsigned CfgIdxBits = 1;

  // parameter defaults
  localparam int unsigned IdBitsDefault    = 16;
  localparam int unsigned CountBitsDefault = 16;

  // draw modes
  typedef enum logic [ModeBits-1:0] {
    DRAW_TRI        = 4'd0,
    DRAW_POLYGON    = 4'd1,
    DRAW_FAN        = 4'd2,
    DRAW_STRIP      = 4'd3,
    DRAW_QUADS      = 4'd4,
    DRAW_QUAD_STRIP = 4'd5,
    DRAW_LINES      = 4'd6,
    DRAW_LINE_LOOP  = 4'd7,
    DRAW_LINE_STRIP = 4'd8
  } draw_mode_e;

  // input item kinds
  typedef enum logic {
    MODE_PUSH  = 1'b0,
    MODE_CLEAR = 1'b1
  } item_mode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DRAW_MODE = 1'b0,
    CFG_EXPECTED  = 1'b1
  } cfg_index_e;

  // result control from the assembler to the output register
  typedef struct packed {
    logic valid;
    logic is_line;
  } prim_ctl_t;

endpackage

@@ hdl/pa_assembler.sv @@
`include "primitive_assembler_macros.svh"

module pa_assembler #(
  parameter int unsigned ID_BITS    = pa_pkg::IdBitsDefault,
  parameter int unsigned COUNT_BITS = pa_pkg::CountBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          clear_i,
  input  logic [ID_BITS-1:0]            vid_i,
  input  logic [pa_pkg::ModeBits-1:0]   draw_mode_i,
  input  logic [pa_pkg::FieldBits-1:0]  expected_i,
  output pa_pkg::prim_ctl_t             ctl_o,
  output logic [ID_BITS-1:0]            corner_a_o,
  output logic [ID_BITS-1:0]            corner_b_o,
  output logic [ID_BITS-1:0]            corner_c_o
);

  localparam int unsigned CmpBits =
    (COUNT_BITS > pa_pkg::FieldBits) ? COUNT_BITS : pa_pkg::FieldBits;

  logic [ID_BITS-1:0]    win_q [3];
  logic [ID_BITS-1:0]    win_d [3];
  logic [1:0]            fill_q, fill_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [ID_BITS-1:0]    saved_q, saved_d;

  logic [ID_BITS-1:0]    shf [3];
  logic [ID_BITS-1:0]    app [3];
  logic [1:0]            base_fill;
  logic [1:0]            new_fill;
  logic [1:0]            drop;
  logic [ID_BITS-1:0]    pivot;
  logic                  last;
  logic                  odd;
  logic                  first;
  pa_pkg::prim_ctl_t     ctl;

  // line loop closes on the expected last primitive
  assign last  = (expected_i != '0) &&
                 (CmpBits'(cnt_q) == CmpBits'(expected_i - 16'd1));
  assign odd   = cnt_q[0];
  assign first = (cnt_q == '0);

  // window append, assembly and consume
  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    saved_d    = saved_q;
    ctl        = '0;
    corner_a_o = '0;
    corner_b_o = '0;
    corner_c_o = '0;
    drop       = 2'd0;

    // make room when full, then append the new vertex
    if (fill_q == 2'd3) begin
      shf[0]    = win_q[1];
      shf[1]    = win_q[2];
      shf[2]    = win_q[2];
      base_fill = 2'd2;
    end else begin
      shf       = win_q;
      base_fill = fill_q;
    end
    for (int i = 0; i < 3; i++) begin
      app[i] = (base_fill == 2'(i)) ? vid_i : shf[i];
    end
    new_fill = base_fill + 2'd1;

    // pivot is taken from the new window on the first primitive
    pivot = first ? app[0] : saved_q;

    if (step_i) begin
      if (clear_i) begin
        fill_d = 2'd0;
        cnt_d  = '0;
      end else begin
        if (draw_mode_i inside {pa_pkg::DRAW_LINES, pa_pkg::DRAW_LINE_LOOP,
                                pa_pkg::DRAW_LINE_STRIP}) begin
          if (new_fill >= 2'd2) begin
            ctl.valid   = 1'b1;
            ctl.is_line = 1'b1;
            corner_a_o  = app[0];
            corner_b_o  = app[1];
            drop        = 2'd1;
            case (draw_mode_i)
              pa_pkg::DRAW_LINES: begin
                drop = 2'd2;
              end
              pa_pkg::DRAW_LINE_LOOP: begin
                saved_d = pivot;
                if (last) begin
                  corner_b_o = pivot;
                end
              end
              default: begin
              end
            endcase
          end
        end else if (new_fill == 2'd3) begin
          ctl.valid  = 1'b1;
          corner_a_o = app[0];
          corner_b_o = app[1];
          corner_c_o = app[2];
          drop       = 2'd1;
          case (draw_mode_i)
            pa_pkg::DRAW_TRI: begin
              drop = 2'd3;
            end
            pa_pkg::DRAW_POLYGON, pa_pkg::DRAW_FAN: begin
              saved_d    = pivot;
              corner_a_o = pivot;
            end
            pa_pkg::DRAW_STRIP: begin
              if (odd) begin
                corner_a_o = app[1];
                corner_b_o = app[0];
              end
            end
            pa_pkg::DRAW_QUADS: begin
              if (odd) begin
                drop       = 2'd3;
                corner_a_o = saved_q;
              end else begin
                saved_d = app[0];
              end
            end
            pa_pkg::DRAW_QUAD_STRIP: begin
              if (odd) begin
                corner_b_o = app[2];
                corner_c_o = app[1];
              end
            end
            default: begin
              // unused draw modes only queue the vertex
              ctl.valid = 1'b0;
              drop      = 2'd0;
            end
          endcase
        end

        // consume entries from the front
        case (drop)
          2'd1: begin
            win_d[0] = app[1];
            win_d[1] = app[2];
            win_d[2] = app[2];
          end
          2'd2: begin
            win_d[0] = app[2];
            win_d[1] = app[2];
            win_d[2] = app[2];
          end
          default: begin
            win_d = app;
          end
        endcase
        fill_d = new_fill - drop;
        if (ctl.valid) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  assign ctl_o = ctl;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
    end
  end

  // vertex storage
  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    saved_q <= saved_d;
  end

  // checks
  `PA_ASSERT(a_clear_empties, step_i && clear_i |=> fill_q == 2'd0 && cnt_q == '0, "clear did not empty the window")
  `PA_ASSERT(a_line_no_third, ctl_o.valid && ctl_o.is_line |-> corner_c_o == '0, "line has a third corner")
  `PA_ASSERT(a_count_on_emit, !(step_i && (clear_i || ctl_o.valid)) |=> $stable(cnt_q), "counter moved without a primitive")
  `PA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> fill_q == 2'd0 || rst_ni, "window not empty after reset")

endmodule

@@ hdl/primitive_assembler.sv @@
// primitive assembler
// turns a stream of vertex ids into triangles or lines following the
// configured draw mode; each vertex yields at most one primitive
// input channel: in_valid_i/in_ready_o with mode_i and vertex_id_i; a clear
// item empties the vertex window and the primitive counter
// output channel: out_valid_o/out_ready_i with corner_a_o..corner_c_o and
// is_line_o; corner_c_o is zero for lines
// config channel: cfg_valid_i/cfg_ready_o, index 0 draw mode, index 1
// expected primitive count; always ready, write only while idle
// a vertex in the input register passes the assembly stage and its primitive
// is registered in the output register when the input register advances
// throughput: one vertex per cycle unless the receiver stalls, set by the
// single assembly stage between the input register and the output register
// reset clears the window fill, counter, config and both valid flags; no
// clearing pass is needed
// when the receiver stalls the output register holds and the input register
// stops advancing, so in_ready_o drops once the input register is occupied
module primitive_assembler #(
  parameter int unsigned ID_BITS    = pa_pkg::IdBitsDefault,
  parameter int unsigned COUNT_BITS = pa_pkg::CountBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [pa_pkg::FieldBits-1:0]   vertex_id_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pa_pkg::FieldBits-1:0]   corner_a_o,
  output logic [pa_pkg::FieldBits-1:0]   corner_b_o,
  output logic [pa_pkg::FieldBits-1:0]   corner_c_o,
  output logic                           is_line_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pa_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [pa_pkg::FieldBits-1:0]   cfg_data_i
);

  localparam int unsigned WideBits =
    (ID_BITS > pa_pkg::FieldBits) ? ID_BITS : pa_pkg::FieldBits;

  logic                          in_valid_q, in_valid_d;
  logic                          in_mode_q;
  logic [pa_pkg::FieldBits-1:0]  in_vid_q;
  logic                          advance;

  logic [pa_pkg::ModeBits-1:0]   draw_mode_q;
  logic [pa_pkg::FieldBits-1:0]  expected_q;

  logic [WideBits-1:0]           vid_wide;
  logic [ID_BITS-1:0]            vid;
  pa_pkg::prim_ctl_t             ctl;
  logic [ID_BITS-1:0]            asm_a, asm_b, asm_c;
  logic [WideBits-1:0]           wide_a, wide_b, wide_c;

  logic                          out_valid_q, out_valid_d;
  logic [pa_pkg::FieldBits-1:0]  out_a_q, out_b_q, out_c_q;
  logic                          out_line_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q <= pa_pkg::DRAW_TRI;
      expected_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pa_pkg::CFG_DRAW_MODE: draw_mode_q <= cfg_data_i[pa_pkg::ModeBits-1:0];
        pa_pkg::CFG_EXPECTED:  expected_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register advances when the output register can take a result
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_mode_q <= mode_i;
      in_vid_q  <= vertex_id_i;
    end
  end

  // resize the id to the internal width
  assign vid_wide = WideBits'(in_vid_q);
  assign vid      = vid_wide[ID_BITS-1:0];

  pa_assembler #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .clear_i     (in_mode_q == pa_pkg::MODE_CLEAR),
    .vid_i       (vid),
    .draw_mode_i (draw_mode_q),
    .expected_i  (expected_q),
    .ctl_o       (ctl),
    .corner_a_o  (asm_a),
    .corner_b_o  (asm_b),
    .corner_c_o  (asm_c)
  );

  assign wide_a = WideBits'(asm_a);
  assign wide_b = WideBits'(asm_b);
  assign wide_c = WideBits'(asm_c);

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = ctl.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ctl.valid) begin
      out_a_q    <= wide_a[pa_pkg::FieldBits-1:0];
      out_b_q    <= wide_b[pa_pkg::FieldBits-1:0];
      out_c_q    <= wide_c[pa_pkg::FieldBits-1:0];
      out_line_q <= ctl.is_line;
    end
  end

  assign out_valid_o = out_valid_q;
  assign corner_a_o  = out_a_q;
  assign corner_b_o  = out_b_q;
  assign corner_c_o  = out_c_q;
  assign is_line_o   = out_line_q;

endmodule
